@@ hw/rtl/dlpd_pkg.sv @@
// ----------------------------------------------------------------------------
// dlpd_pkg
// Shared types and constants of the line-number program decoder.
// ----------------------------------------------------------------------------
package dlpd_pkg;

    localparam int ADDR_W    = 64;
    localparam int LINE_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_OPS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_STMT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BASE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_RANGE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_BASE    = 3'd5;

    localparam logic [1:0] ST_ROW     = 2'd0;
    localparam logic [1:0] ST_FINAL   = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_BADLEN  = 2'd3;

    localparam logic [7:0] OP_EXTENDED      = 8'd0;
    localparam logic [7:0] OP_COPY          = 8'd1;
    localparam logic [7:0] OP_ADVANCE_PC    = 8'd2;
    localparam logic [7:0] OP_ADVANCE_LINE  = 8'd3;
    localparam logic [7:0] OP_SET_FILE      = 8'd4;
    localparam logic [7:0] OP_SET_COLUMN    = 8'd5;
    localparam logic [7:0] OP_NEGATE_STMT   = 8'd6;
    localparam logic [7:0] OP_BASIC_BLOCK   = 8'd7;
    localparam logic [7:0] OP_CONST_ADD_PC  = 8'd8;
    localparam logic [7:0] OP_FIXED_ADV_PC  = 8'd9;
    localparam logic [7:0] OP_PROLOGUE_END  = 8'd10;
    localparam logic [7:0] OP_EPILOGUE_BEG  = 8'd11;
    localparam logic [7:0] OP_SET_ISA       = 8'd12;
    localparam logic [7:0] EXT_END_SEQ      = 8'd1;
    localparam logic [7:0] EXT_SET_ADDRESS  = 8'd2;
    localparam logic [7:0] SPECIAL_TOP      = 8'd255;

    typedef enum logic [2:0] {
        PH_OPCODE, PH_ULEB, PH_FIXED, PH_EXT_LEN, PH_EXT_OP, PH_EXT_BODY
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DIVA, S_ADV, S_DIVB, S_DIVC, S_MUL, S_ADD, S_EMIT
    } state_t;

    typedef enum logic {K_SPECIAL, K_ADVANCE} kind_t;

    typedef struct packed {
        logic [7:0] min_len;
        logic [7:0] max_ops;
        logic       def_stmt;
        logic [7:0] line_base;
        logic [7:0] line_range;
        logic [7:0] op_base;
    } cfg_t;

    typedef struct packed {
        logic       fin;
        logic [7:0] data;
    } item_t;

endpackage

@@ hw/rtl/dwarf_line_program_decoder_core.sv @@
// ----------------------------------------------------------------------------
// dwarf_line_program_decoder_core
// Line-number program decoder: byte queue, configuration registers and engine.
// ----------------------------------------------------------------------------
// a word is registered in the queue when accepted; a plain byte is consumed
//   in S_IDLE, one with results then sends them one at a time from S_EMIT
// special opcode / const_add_pc: S_DIVA, S_ADV, S_MUL, S_ADD, with S_DIVB and
//   S_DIVC before S_MUL if max_ops_per_instr > 1; advance_pc enters at S_ADV
// input: one word per cycle into a 4-word queue while s_tready is high
// reset: synchronous active-low aresetn restores control state and config
module dwarf_line_program_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // program_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // row_address, row_line
    output logic [1:0]  m_tuser,   // status
    output logic        m_tlast,   // last_in_run
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);
    import dlpd_pkg::*;

    cfg_t              cfg_reg;
    item_t             item;
    logic              item_valid, item_pop;
    logic [ADDR_W-1:0] res_addr;
    logic [LINE_W-1:0] res_line;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{min_len: 8'd1, max_ops: 8'd1, def_stmt: 1'b1,
                         line_base: 8'hFB, line_range: 8'd14, op_base: 8'd13};
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MIN_LEN:    cfg_reg.min_len    <= cfg_wdata;
                CFG_MAX_OPS:    cfg_reg.max_ops    <= cfg_wdata;
                CFG_DEF_STMT:   cfg_reg.def_stmt   <= cfg_wdata[0];
                CFG_LINE_BASE:  cfg_reg.line_base  <= cfg_wdata;
                CFG_LINE_RANGE: cfg_reg.line_range <= cfg_wdata;
                CFG_OP_BASE:    cfg_reg.op_base    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    dlpd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    dlpd_exec u_exec (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .res_addr   (res_addr),
        .res_line   (res_line),
        .res_status (m_tuser),
        .m_tlast    (m_tlast)
    );

    assign m_tdata = {32'(res_line), 64'(res_addr)};

endmodule

@@ hw/rtl/dlpd_front.sv @@
// ----------------------------------------------------------------------------
// dlpd_front
// Input side: takes program bytes and queues them for the execution engine.
// ----------------------------------------------------------------------------
module dlpd_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,   // program_byte
    input  logic            s_tlast,   // final_byte
    output logic            item_valid,
    output dlpd_pkg::item_t item,
    input  logic            item_pop
);
    import dlpd_pkg::*;

    item_t          q_mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   cnt_reg, cnt_next;
    logic            push, pop;

    assign s_tready   = (cnt_reg != Q_AW'(0) + (Q_AW+1)'(Q_DEPTH));
    assign item_valid = (cnt_reg != '0);
    assign item       = q_mem_reg[rd_ptr_reg];
    assign push       = s_tvalid && s_tready;
    assign pop        = item_pop && item_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= '{fin: s_tlast, data: s_tdata};
        end
    end

endmodule

@@ hw/rtl/dlpd_exec.sv @@
// ----------------------------------------------------------------------------
// dlpd_exec
// Execution engine: opcode parser, line registers, serial divider for address and
// line advances and the result output register.
// ----------------------------------------------------------------------------
module dlpd_exec (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  dlpd_pkg::cfg_t              cfg,
    input  logic                        item_valid,
    input  dlpd_pkg::item_t             item,
    output logic                        item_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [dlpd_pkg::ADDR_W-1:0] res_addr,
    output logic [dlpd_pkg::LINE_W-1:0] res_line,
    output logic [1:0]                  res_status,
    output logic                        m_tlast
);
    import dlpd_pkg::*;

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    kind_t               kind_reg, kind_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [7:0]          opi_reg, opi_next;
    logic [LINE_W-1:0]   line_reg, line_next;
    logic [31:0]         file_reg, file_next, col_reg, col_next, view_reg, view_next;
    logic                stmt_reg, stmt_next, bb_reg, bb_next, halt_reg, halt_next;
    logic [7:0]          pend_reg, pend_next;
    logic [63:0]         acc_reg, acc_next;
    logic [6:0]          sh_reg, sh_next;
    logic [31:0]         rem_reg, rem_next;
    logic                fin_reg, fin_next;
    logic [63:0]         adv_reg, adv_next, q1_reg, q1_next, qsum_reg, qsum_next;
    logic [LINE_W-1:0]   inc_reg, inc_next;
    logic [ADDR_W-1:0]   delta_reg, delta_next;
    logic [63:0]         dq_reg, dq_next;
    logic [7:0]          dr_reg, dr_next, dd_reg, dd_next;
    logic [6:0]          dcnt_reg, dcnt_next;
    logic                e1_reg, e1_next, et_reg, et_next, ef_reg, ef_next;
    logic [1:0]          e1st_reg, e1st_next;
    logic                mv_reg, mv_next, ml_reg, ml_next;
    logic [ADDR_W-1:0]   ma_reg, ma_next;
    logic [LINE_W-1:0]   mln_reg, mln_next;
    logic [1:0]          mst_reg, mst_next;

    logic [8:0]  rr;
    logic        ge;
    logic [7:0]  r_step, lr, mx, b;
    logic [63:0] q_step, v;
    logic [71:0] prod;
    logic [31:0] inc32;
    logic [8:0]  s9;
    logic        fin, done, row_v, out_free, leb_end;
    logic [1:0]  row_st;

    assign m_tvalid   = mv_reg;
    assign res_addr   = ma_reg;
    assign res_line   = mln_reg;
    assign res_status = mst_reg;
    assign m_tlast    = ml_reg;

    // one quotient bit per cycle
    assign rr     = {dr_reg, dq_reg[63]};
    assign ge     = rr >= {1'b0, dd_reg};
    assign r_step = ge ? 8'(rr - {1'b0, dd_reg}) : rr[7:0];
    assign q_step = {dq_reg[62:0], ge};
    assign lr     = (cfg.line_range == '0) ? 8'd1 : cfg.line_range;
    assign mx     = (cfg.max_ops == '0) ? 8'd1 : cfg.max_ops;
    assign prod   = qsum_reg * cfg.min_len;
    assign inc32  = {24'd0, r_step} + {{24{cfg.line_base[7]}}, cfg.line_base};
    assign s9     = {1'b0, r_step} + {1'b0, opi_reg};
    assign out_free = !mv_reg || m_tready;
    assign b      = item.data;

    always_comb begin
        state_next = state_reg;  phase_next = phase_reg; kind_next = kind_reg;
        addr_next = addr_reg;    opi_next = opi_reg;     line_next = line_reg;
        file_next = file_reg;    col_next = col_reg;     view_next = view_reg;
        stmt_next = stmt_reg;    bb_next = bb_reg;       halt_next = halt_reg;
        pend_next = pend_reg;    acc_next = acc_reg;     sh_next = sh_reg;
        rem_next = rem_reg;      fin_next = fin_reg;     adv_next = adv_reg;
        q1_next = q1_reg;        qsum_next = qsum_reg;   inc_next = inc_reg;
        delta_next = delta_reg;  dq_next = dq_reg;       dr_next = dr_reg;
        dd_next = dd_reg;        dcnt_next = dcnt_reg;
        e1_next = e1_reg; e1st_next = e1st_reg; et_next = et_reg; ef_next = ef_reg;
        mv_next = mv_reg && !m_tready;
        ma_next = ma_reg; mln_next = mln_reg; mst_next = mst_reg; ml_next = ml_reg;
        item_pop = 1'b0;
        done = 1'b0; row_v = 1'b0; row_st = ST_ROW;
        fin = fin_reg; leb_end = 1'b0; v = '0;

        case (state_reg)
            S_IDLE: begin
                if (item_valid) begin
                    item_pop = 1'b1;
                    fin      = item.fin;
                    done     = 1'b1;
                    if (!halt_reg) begin
                        case (phase_reg)
                            PH_ULEB, PH_EXT_LEN: begin
                                if (sh_reg < 7'd64) begin
                                    acc_next = acc_reg | (64'(b[6:0]) << sh_reg[5:0]);
                                    sh_next  = sh_reg + 7'd7;
                                end
                                leb_end = !b[7];
                            end
                            default: ;
                        endcase
                        case (phase_reg)
                            PH_ULEB: begin
                                if (leb_end) begin
                                    v = acc_next;
                                    case (pend_reg)
                                        OP_ADVANCE_PC: begin
                                            adv_next  = v;
                                            kind_next = K_ADVANCE;
                                            state_next = S_ADV;
                                            done = 1'b0;
                                        end
                                        OP_ADVANCE_LINE: begin
                                            if (sh_next < 7'd64 && b[6]) begin
                                                v = v | ({64{1'b1}} << sh_next[5:0]);
                                            end
                                            line_next = line_reg + v[LINE_W-1:0];
                                        end
                                        OP_SET_FILE:   file_next = v[31:0];
                                        OP_SET_COLUMN: col_next = v[31:0];
                                        default: ;
                                    endcase
                                    phase_next = PH_OPCODE; pend_next = '0;
                                    acc_next = '0; sh_next = '0; rem_next = '0;
                                end
                            end
                            PH_FIXED: begin
                                acc_next = acc_reg | (64'(b) << (sh_reg[3] ? 4'd8 : 4'd0));
                                sh_next  = sh_reg + 7'd8;
                                if (sh_next >= 7'd16) begin
                                    addr_next = addr_reg + acc_next[ADDR_W-1:0];
                                    opi_next  = '0;
                                    phase_next = PH_OPCODE; pend_next = '0;
                                    acc_next = '0; sh_next = '0; rem_next = '0;
                                end
                            end
                            PH_EXT_LEN: begin
                                if (leb_end) begin
                                    if (acc_next == '0) begin
                                        row_v = 1'b1; row_st = ST_BADLEN;
                                        phase_next = PH_OPCODE; pend_next = '0;
                                        acc_next = '0; sh_next = '0; rem_next = '0;
                                    end else begin
                                        v = acc_next - 64'd1;
                                        rem_next = (v[63:32] != '0) ? '1 : v[31:0];
                                        acc_next = '0; sh_next = '0;
                                        phase_next = PH_EXT_OP;
                                    end
                                end
                            end
                            PH_EXT_OP, PH_EXT_BODY: begin
                                if (phase_reg == PH_EXT_OP) begin
                                    pend_next = b;
                                end else begin
                                    if (pend_reg == EXT_SET_ADDRESS && sh_reg < 7'd64) begin
                                        acc_next = acc_reg | (64'(b) << sh_reg[5:0]);
                                    end
                                    if (sh_reg < 7'd72) sh_next = sh_reg + 7'd8;
                                    rem_next = rem_reg - 32'd1;
                                end
                                if (rem_next == '0) begin
                                    if (pend_next == EXT_END_SEQ) begin
                                        addr_next = '0; opi_next = '0; line_next = LINE_W'(1);
                                        file_next = 32'd1; col_next = '0;
                                        stmt_next = cfg.def_stmt; bb_next = 1'b0;
                                        view_next = '0;
                                    end else if (pend_next == EXT_SET_ADDRESS) begin
                                        addr_next = (sh_next > 7'd64) ? '0
                                                                      : acc_next[ADDR_W-1:0];
                                        view_next = '0; opi_next = '0;
                                    end
                                    phase_next = PH_OPCODE; pend_next = '0;
                                    acc_next = '0; sh_next = '0; rem_next = '0;
                                end else begin
                                    phase_next = PH_EXT_BODY;
                                end
                            end
                            default: begin
                                if (b >= cfg.op_base) begin
                                    dq_next = {8'(b - cfg.op_base), 56'd0};
                                    dr_next = '0; dd_next = lr; dcnt_next = 7'd8;
                                    kind_next = K_SPECIAL;
                                    state_next = S_DIVA; done = 1'b0;
                                    phase_next = PH_OPCODE; pend_next = '0;
                                    acc_next = '0; sh_next = '0; rem_next = '0;
                                end else begin
                                    case (b)
                                        OP_EXTENDED: begin
                                            phase_next = PH_EXT_LEN; pend_next = '0;
                                            acc_next = '0; sh_next = '0; rem_next = '0;
                                        end
                                        OP_COPY: view_next = view_reg + 32'd1;
                                        OP_ADVANCE_PC, OP_ADVANCE_LINE, OP_SET_FILE,
                                        OP_SET_COLUMN, OP_SET_ISA: begin
                                            phase_next = PH_ULEB; pend_next = b;
                                            acc_next = '0; sh_next = '0; rem_next = '0;
                                        end
                                        OP_NEGATE_STMT: stmt_next = !stmt_reg;
                                        OP_BASIC_BLOCK: bb_next = 1'b1;
                                        OP_CONST_ADD_PC: begin
                                            dq_next = {8'(SPECIAL_TOP - cfg.op_base), 56'd0};
                                            dr_next = '0; dd_next = lr; dcnt_next = 7'd8;
                                            kind_next = K_ADVANCE;
                                            state_next = S_DIVA; done = 1'b0;
                                        end
                                        OP_FIXED_ADV_PC: begin
                                            phase_next = PH_FIXED; pend_next = '0;
                                            acc_next = '0; sh_next = '0; rem_next = '0;
                                        end
                                        OP_PROLOGUE_END, OP_EPILOGUE_BEG: ;
                                        default: begin
                                            row_v = 1'b1; row_st = ST_UNKNOWN;
                                            halt_next = 1'b1;
                                        end
                                    endcase
                                end
                            end
                        endcase
                    end
                    fin_next = item.fin;
                end
            end
            S_DIVA: begin
                dq_next = q_step; dr_next = r_step; dcnt_next = dcnt_reg - 7'd1;
                if (dcnt_reg == 7'd1) begin
                    adv_next   = q_step;
                    inc_next   = inc32[LINE_W-1:0];
                    state_next = S_ADV;
                end
            end
            S_ADV: begin
                if (mx == 8'd1) begin
                    qsum_next  = adv_reg;
                    state_next = S_MUL;
                end else begin
                    dq_next = adv_reg; dr_next = '0; dd_next = mx; dcnt_next = 7'd64;
                    state_next = S_DIVB;
                end
            end
            S_DIVB: begin
                dq_next = q_step; dr_next = r_step; dcnt_next = dcnt_reg - 7'd1;
                if (dcnt_reg == 7'd1) begin
                    q1_next = q_step;
                    dq_next = {s9, 55'd0}; dr_next = '0; dcnt_next = 7'd9;
                    state_next = S_DIVC;
                end
            end
            S_DIVC: begin
                dq_next = q_step; dr_next = r_step; dcnt_next = dcnt_reg - 7'd1;
                if (dcnt_reg == 7'd1) begin
                    opi_next   = r_step;
                    qsum_next  = q1_reg + q_step;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                delta_next = prod[ADDR_W-1:0];
                state_next = S_ADD;
            end
            S_ADD: begin
                done = 1'b1;
                addr_next = addr_reg + delta_reg;
                if (delta_reg != '0) view_next = '0;
                if (kind_reg == K_SPECIAL) begin
                    line_next = line_reg + inc_reg;
                    view_next = ((delta_reg != '0) ? 32'd0 : view_reg) + 32'd1;
                    if (opi_reg == '0) row_v = 1'b1;
                end
            end
            S_EMIT: begin
                if (e1_reg || et_reg || ef_reg) begin
                    if (out_free) begin
                        mv_next = 1'b1; ma_next = addr_reg; mln_next = line_reg;
                        if (e1_reg) begin
                            e1_next = 1'b0; mst_next = e1st_reg;
                            ml_next = !(et_reg || ef_reg);
                        end else if (et_reg) begin
                            et_next = 1'b0; mst_next = ST_BADLEN; ml_next = !ef_reg;
                        end else begin
                            ef_next = 1'b0; mst_next = ST_FINAL; ml_next = 1'b1;
                        end
                    end
                end else begin
                    if (fin_reg) begin
                        addr_next = '0; opi_next = '0; line_next = LINE_W'(1);
                        file_next = 32'd1; col_next = '0; stmt_next = cfg.def_stmt;
                        bb_next = 1'b0; view_next = '0; halt_next = 1'b0;
                        phase_next = PH_OPCODE; pend_next = '0;
                        acc_next = '0; sh_next = '0; rem_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (done) begin
            e1_next   = row_v;
            e1st_next = row_st;
            et_next   = fin && !halt_next && (phase_next == PH_EXT_LEN ||
                        phase_next == PH_EXT_OP || phase_next == PH_EXT_BODY);
            ef_next   = fin && !halt_next;
            state_next = (row_v || fin) ? S_EMIT : S_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;   phase_reg <= PH_OPCODE;
            addr_reg <= '0;        opi_reg <= '0;         line_reg <= LINE_W'(1);
            file_reg <= 32'd1;     col_reg <= '0;         view_reg <= '0;
            stmt_reg <= 1'b1;      bb_reg <= 1'b0;        halt_reg <= 1'b0;
            pend_reg <= '0;        acc_reg <= '0;         sh_reg <= '0;
            rem_reg <= '0;         fin_reg <= 1'b0;
            e1_reg <= 1'b0;        et_reg <= 1'b0;        ef_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next; phase_reg <= phase_next;
            addr_reg <= addr_next;   opi_reg <= opi_next;   line_reg <= line_next;
            file_reg <= file_next;   col_reg <= col_next;   view_reg <= view_next;
            stmt_reg <= stmt_next;   bb_reg <= bb_next;     halt_reg <= halt_next;
            pend_reg <= pend_next;   acc_reg <= acc_next;   sh_reg <= sh_next;
            rem_reg <= rem_next;     fin_reg <= fin_next;
            e1_reg <= e1_next;       et_reg <= et_next;     ef_reg <= ef_next;
            mv_reg <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;   adv_reg <= adv_next;   q1_reg <= q1_next;
        qsum_reg <= qsum_next;   inc_reg <= inc_next;   delta_reg <= delta_next;
        dq_reg <= dq_next;       dr_reg <= dr_next;     dd_reg <= dd_next;
        dcnt_reg <= dcnt_next;   e1st_reg <= e1st_next;
        ma_reg <= ma_next;       mln_reg <= mln_next;   mst_reg <= mst_next;
        ml_reg <= ml_next;
    end

endmodule

@@ hw/rtl/dlpd_checker.sv @@
// ----------------------------------------------------------------------------
// dlpd_checker
// Port-level checks of the decoder result stream, bound to the top level.
// ----------------------------------------------------------------------------
module dlpd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);
    import dlpd_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_final_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_FINAL |-> m_tlast)
        else $error("final row not last of its byte");

    a_unknown_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_UNKNOWN |-> m_tlast)
        else $error("unknown opcode result followed by more");

    a_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser == ST_FINAL)
        else $error("non-last result not followed by final row");

endmodule

bind dwarf_line_program_decoder_core dlpd_checker u_dlpd_checker (.*);
